// File: rtl/mbri_pkg.sv
// Shared constants and types for the discrete-input response parser.
package mbri_pkg;

    localparam int BYTE_W     = 8;
    localparam int REG_NUM_W  = 16;
    localparam int COUNT_W    = 11;
    localparam int NBITS_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int CRC_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;

    localparam logic [BYTE_W-1:0] MAX_DATA_BYTES   = 8'd250;
    localparam logic [BYTE_W-1:0] FUNC_READ_INPUTS = 8'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INPUT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT      = 2'd2;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;

    typedef logic [CRC_W-1:0] crc_t;

endpackage

// File: rtl/mbri_crc_byte.sv
// Modbus CRC-16 update over one byte, LSB first.
module mbri_crc_byte
    import mbri_pkg::*;
(
    input  crc_t              crc_in,
    input  logic [BYTE_W-1:0] data_in,
    output crc_t              crc_out
);

    always_comb begin
        crc_t c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// File: rtl/modbus_read_inputs_response_parser_core.sv
// Modbus RTU read-discrete-inputs response parser, top level.
//
// Response frame bytes enter on the s_ channel, one transfer per byte; s_frame_start
// marks the address byte of a new frame. Each data byte that still carries requested
// inputs produces one data result on the m_ channel (up to 8 bits plus the number of
// the first input); the CRC high byte produces one status result (ok, CRC error,
// address or function mismatch). Data results precede the CRC check, so the
// consumer drops them when the status is bad. Other bytes produce no result.
// Throughput: one byte per cycle while s_ready is high; the frame state and the
// unrolled 8-bit CRC update are done in the cycle the byte is taken, and the result
// lands in a single output register. s_ready stays high while the output register
// is empty or being drained, so a stalled receiver holds at most one result and then
// backs up the sender. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect at once; the user must make them while no frame is in flight; the block
// does not enforce it. Reset (aresetn low, synchronous) empties the output register,
// restores the register defaults and waits for an address byte.
module modbus_read_inputs_response_parser_core
    import mbri_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_rx_byte,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_result_kind,
    output logic [REG_NUM_W-1:0]  m_first_register,
    output logic [BYTE_W-1:0]     m_bit_values,
    output logic [NBITS_W-1:0]    m_bit_count,
    output logic [STATUS_W-1:0]   m_frame_status,
    output logic [BYTE_W-1:0]     m_resp_address,
    output logic [BYTE_W-1:0]     m_resp_function
);

    localparam logic [2:0] PH_ADDR  = 3'd0;
    localparam logic [2:0] PH_FUNC  = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CRCLO = 3'd4;
    localparam logic [2:0] PH_CRCHI = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    // configuration
    logic [BYTE_W-1:0]    exp_addr_reg;
    logic [REG_NUM_W-1:0] first_input_reg;
    logic [COUNT_W-1:0]   input_count_reg;

    // frame state
    logic [2:0]           phase_reg, phase_next;
    logic [BYTE_W-1:0]    data_len_reg, data_len_next;
    crc_t                 crc_reg, crc_next;
    logic [BYTE_W-1:0]    rx_addr_reg, rx_addr_next;
    logic [BYTE_W-1:0]    rx_func_reg, rx_func_next;
    logic [COUNT_W-1:0]   bits_done_reg, bits_done_next;
    logic [BYTE_W-1:0]    crc_lo_reg, crc_lo_next;

    // output register
    logic                 out_valid_reg;
    logic                 kind_reg, kind_next;
    logic [REG_NUM_W-1:0] first_reg_reg, first_reg_next;
    logic [BYTE_W-1:0]    bit_values_reg, bit_values_next;
    logic [NBITS_W-1:0]   bit_count_reg, bit_count_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [BYTE_W-1:0]    out_addr_reg, out_addr_next;
    logic [BYTE_W-1:0]    out_func_reg, out_func_next;
    logic                 emit;

    logic                 s_xfer;
    logic [2:0]           cur_phase;
    crc_t                 cur_crc;
    logic [COUNT_W-1:0]   cur_bits;
    crc_t                 crc_upd;
    logic [COUNT_W-1:0]   bits_left;
    logic [NBITS_W-1:0]   nbits;
    logic                 crc_ok;

    assign s_ready = !out_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    // frame start restarts the frame before this byte is parsed
    assign cur_phase = s_frame_start ? PH_ADDR : phase_reg;
    assign cur_crc   = s_frame_start ? CRC_INIT : crc_reg;
    assign cur_bits  = s_frame_start ? '0 : bits_done_reg;

    mbri_crc_byte u_crc (
        .crc_in  (cur_crc),
        .data_in (s_rx_byte),
        .crc_out (crc_upd)
    );

    assign bits_left = input_count_reg - cur_bits;
    assign nbits     = (bits_left > COUNT_W'(8)) ? NBITS_W'(8) : bits_left[NBITS_W-1:0];
    assign crc_ok    = (crc_lo_reg == cur_crc[7:0]) && (s_rx_byte == cur_crc[15:8]);

    always_comb begin
        phase_next      = cur_phase;
        data_len_next   = s_frame_start ? '0 : data_len_reg;
        crc_next        = cur_crc;
        rx_addr_next    = rx_addr_reg;
        rx_func_next    = rx_func_reg;
        bits_done_next  = cur_bits;
        crc_lo_next     = s_frame_start ? '0 : crc_lo_reg;
        emit            = 1'b0;
        kind_next       = KIND_DATA;
        first_reg_next  = '0;
        bit_values_next = '0;
        bit_count_next  = '0;
        status_next     = STATUS_OK;
        out_addr_next   = rx_addr_reg;
        out_func_next   = rx_func_reg;
        unique case (cur_phase)
            PH_ADDR: begin
                rx_addr_next = s_rx_byte;
                crc_next     = crc_upd;
                phase_next   = PH_FUNC;
            end
            PH_FUNC: begin
                rx_func_next = s_rx_byte;
                crc_next     = crc_upd;
                phase_next   = PH_COUNT;
            end
            PH_COUNT: begin
                crc_next      = crc_upd;
                data_len_next = (s_rx_byte > MAX_DATA_BYTES) ? MAX_DATA_BYTES : s_rx_byte;
                phase_next    = (s_rx_byte == '0) ? PH_CRCLO : PH_DATA;
            end
            PH_DATA: begin
                crc_next      = crc_upd;
                data_len_next = data_len_reg - 1'b1;
                if (data_len_reg == 8'd1) begin
                    phase_next = PH_CRCLO;
                end
                if (input_count_reg > cur_bits) begin
                    emit            = 1'b1;
                    first_reg_next  = first_input_reg + {{(REG_NUM_W-COUNT_W){1'b0}}, cur_bits};
                    bit_values_next = s_rx_byte & ~(8'hFF << nbits);
                    bit_count_next  = nbits;
                    bits_done_next  = cur_bits + {{(COUNT_W-NBITS_W){1'b0}}, nbits};
                end
            end
            PH_CRCLO: begin
                crc_lo_next = s_rx_byte;
                phase_next  = PH_CRCHI;
            end
            PH_CRCHI: begin
                emit       = 1'b1;
                kind_next  = KIND_STATUS;
                phase_next = PH_DONE;
                if (!crc_ok) begin
                    status_next = STATUS_CRC_ERR;
                end else if (rx_addr_reg != exp_addr_reg
                             || rx_func_reg != FUNC_READ_INPUTS) begin
                    status_next = STATUS_MISMATCH;
                end else begin
                    status_next = STATUS_OK;
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_addr_reg    <= 8'd1;
            first_input_reg <= '0;
            input_count_reg <= 11'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_EXPECTED_ADDRESS: exp_addr_reg    <= cfg_data[BYTE_W-1:0];
                CFG_FIRST_INPUT:      first_input_reg <= cfg_data[REG_NUM_W-1:0];
                CFG_INPUT_COUNT:      input_count_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ADDR;
            data_len_reg  <= '0;
            crc_reg       <= CRC_INIT;
            rx_addr_reg   <= '0;
            rx_func_reg   <= '0;
            bits_done_reg <= '0;
            crc_lo_reg    <= '0;
        end else if (s_xfer) begin
            phase_reg     <= phase_next;
            data_len_reg  <= data_len_next;
            crc_reg       <= crc_next;
            rx_addr_reg   <= rx_addr_next;
            rx_func_reg   <= rx_func_next;
            bits_done_reg <= bits_done_next;
            crc_lo_reg    <= crc_lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && emit) begin
            kind_reg       <= kind_next;
            first_reg_reg  <= first_reg_next;
            bit_values_reg <= bit_values_next;
            bit_count_reg  <= bit_count_next;
            status_reg     <= status_next;
            out_addr_reg   <= out_addr_next;
            out_func_reg   <= out_func_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = kind_reg;
    assign m_first_register = first_reg_reg;
    assign m_bit_values     = bit_values_reg;
    assign m_bit_count      = bit_count_reg;
    assign m_frame_status   = status_reg;
    assign m_resp_address   = out_addr_reg;
    assign m_resp_function  = out_func_reg;

    a_status_no_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_STATUS |-> m_bit_count == '0 && m_bit_values == '0)
        else $error("status result carries data bits");

    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_DATA
            |-> m_bit_count != '0 && m_bit_count <= NBITS_W'(8) && m_frame_status == STATUS_OK)
        else $error("data result has bad bit count or status");

    a_bits_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_DATA && m_bit_count < NBITS_W'(8)
            |-> (m_bit_values >> m_bit_count) == '0)
        else $error("bits above bit count not cleared");

    a_data_len: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> data_len_reg != '0 && data_len_reg <= MAX_DATA_BYTES)
        else $error("data phase with bad remaining length");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_status != 2'd3)
        else $error("undefined frame status");

endmodule

// File: dv/tb_modbus_read_inputs_response_parser_core.sv
// Self-checking testbench for the Modbus read-discrete-inputs response parser core.
`timescale 1ns / 1ps

module tb_modbus_read_inputs_response_parser_core;
    import mbri_pkg::*;

    localparam int DIR_ROWS    = 25;
    localparam int N_PHASES    = 8;
    localparam int PHASE_BYTES = 100;
    localparam int LONG_HOLD   = 400;
    localparam int QUIET_CYCLES = 4;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        FR_ADDRESS, FR_FUNCTION, FR_COUNT, FR_DATA, FR_CRC_LO, FR_CRC_HI, FR_DONE
    } frame_phase_t;

    // where a directed byte comes from
    typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI} byte_src_t;
    // how a directed row is checked
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_chk_t;

    typedef struct packed {
        logic                 kind;
        logic [REG_NUM_W-1:0] first_reg;
        logic [BYTE_W-1:0]    bit_vals;
        logic [NBITS_W-1:0]   nbits;
        logic [STATUS_W-1:0]  status;
        logic [BYTE_W-1:0]    addr;
        logic [BYTE_W-1:0]    func;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] val;
        logic              st;
        byte_src_t         src;
        logic [BYTE_W-1:0] flip;
        row_chk_t          chk;
        result_t           want;
    } stim_row_t;

    localparam result_t NO_RES = '0;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_rx_byte = '0;
    logic                  s_frame_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_result_kind;
    logic [REG_NUM_W-1:0]  m_first_register;
    logic [BYTE_W-1:0]     m_bit_values;
    logic [NBITS_W-1:0]    m_bit_count;
    logic [STATUS_W-1:0]   m_frame_status;
    logic [BYTE_W-1:0]     m_resp_address;
    logic [BYTE_W-1:0]     m_resp_function;

    modbus_read_inputs_response_parser_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_first_register(m_first_register),
        .m_bit_values    (m_bit_values),
        .m_bit_count     (m_bit_count),
        .m_frame_status  (m_frame_status),
        .m_resp_address  (m_resp_address),
        .m_resp_function (m_resp_function)
    );

    // parser model state and its register copies
    frame_phase_t          fr_phase;
    logic [BYTE_W-1:0]     fr_left;
    crc_t                  fr_crc;
    logic [BYTE_W-1:0]     fr_addr;
    logic [BYTE_W-1:0]     fr_func;
    logic [COUNT_W-1:0]    fr_bits;
    logic [BYTE_W-1:0]     fr_crc_lo;
    logic [BYTE_W-1:0]     cfg_addr_q;
    logic [REG_NUM_W-1:0]  cfg_first_q;
    logic [COUNT_W-1:0]    cfg_count_q;

    result_t   pending_results[$];
    stim_row_t dir_rows[DIR_ROWS];

    int errors = 0;
    int bytes_taken = 0;
    int frames_sent = 0;
    int n_data = 0;
    int n_ok = 0;
    int n_crc_err = 0;
    int n_mismatch = 0;
    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    logic hold_on = 1'b0;
    event hold_go;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("tb_modbus_read_inputs_response_parser_core failed");
        $finish;
    end

    function automatic crc_t crc16_byte(crc_t c, logic [BYTE_W-1:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic string result_str(result_t r);
        return $sformatf("kind=%0d first=%h bits=%h cnt=%0d status=%0d addr=%h func=%h",
                         r.kind, r.first_reg, r.bit_vals, r.nbits, r.status, r.addr,
                         r.func);
    endfunction

    task automatic frame_restart_model();
        fr_phase  = FR_ADDRESS;
        fr_left   = '0;
        fr_crc    = CRC_INIT;
        fr_bits   = '0;
        fr_crc_lo = '0;
    endtask

    task automatic model_reset();
        cfg_addr_q  = 8'h01;
        cfg_first_q = 16'h0000;
        cfg_count_q = 11'd1;
        frame_restart_model();
        fr_addr = '0;
        fr_func = '0;
    endtask

    // advance the parser model by one byte; ign is set when the byte falls after a frame
    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic st, output logic got,
                              output result_t r, output logic ign);
        logic [COUNT_W-1:0] left;
        logic [NBITS_W-1:0] n;
        logic               crc_good;
        got = 1'b0;
        r   = '0;
        ign = 1'b0;
        if (st)
            frame_restart_model();
        case (fr_phase)
            FR_ADDRESS: begin
                fr_addr  = b;
                fr_crc   = crc16_byte(fr_crc, b);
                fr_phase = FR_FUNCTION;
            end
            FR_FUNCTION: begin
                fr_func  = b;
                fr_crc   = crc16_byte(fr_crc, b);
                fr_phase = FR_COUNT;
            end
            FR_COUNT: begin
                fr_crc   = crc16_byte(fr_crc, b);
                fr_left  = (b > MAX_DATA_BYTES) ? MAX_DATA_BYTES : b;
                fr_phase = (fr_left == 0) ? FR_CRC_LO : FR_DATA;
            end
            FR_DATA: begin
                fr_crc  = crc16_byte(fr_crc, b);
                fr_left = fr_left - 1'b1;
                if (fr_left == 0)
                    fr_phase = FR_CRC_LO;
                if (cfg_count_q > fr_bits) begin
                    left        = cfg_count_q - fr_bits;
                    n           = (left > 11'd8) ? 4'd8 : left[NBITS_W-1:0];
                    got         = 1'b1;
                    r.kind      = KIND_DATA;
                    r.first_reg = cfg_first_q + 16'(fr_bits);
                    r.bit_vals  = b & 8'((16'd1 << n) - 16'd1);
                    r.nbits     = n;
                    r.status    = STATUS_OK;
                    r.addr      = fr_addr;
                    r.func      = fr_func;
                    fr_bits     = fr_bits + 11'(n);
                end
            end
            FR_CRC_LO: begin
                fr_crc_lo = b;
                fr_phase  = FR_CRC_HI;
            end
            FR_CRC_HI: begin
                crc_good = (fr_crc_lo == fr_crc[7:0]) && (b == fr_crc[15:8]);
                got      = 1'b1;
                r.kind   = KIND_STATUS;
                if (!crc_good)
                    r.status = STATUS_CRC_ERR;
                else if (fr_addr != cfg_addr_q || fr_func != FUNC_READ_INPUTS)
                    r.status = STATUS_MISMATCH;
                else
                    r.status = STATUS_OK;
                r.addr   = fr_addr;
                r.func   = fr_func;
                fr_phase = FR_DONE;
            end
            default: ign = 1'b1;
        endcase
    endtask

    // present one byte, with a random gap before it, and wait for its transfer
    task automatic drive_byte(input logic [BYTE_W-1:0] b, input logic st);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < snd_idle_pct)
                @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_rx_byte     <= b;
        s_frame_start <= st;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic st);
        logic    got;
        logic    ign;
        result_t r;
        parse_byte(b, st, got, r, ign);
        if (got)
            pending_results.push_back(r);
        if (!ign)
            bytes_taken++;
        drive_byte(b, st);
    endtask

    task automatic send_random_frame();
        int                sel;
        int                cnt;
        int                total;
        int                cut;
        logic [BYTE_W-1:0] a0;
        logic [BYTE_W-1:0] fn;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] flo;
        logic [BYTE_W-1:0] fhi;
        logic              st0;
        frames_sent++;
        if ($urandom_range(0, 99) < 8) begin
            // line noise with the odd frame start
            repeat ($urandom_range(1, 6))
                feed_byte(8'($urandom), $urandom_range(0, 9) == 0);
            return;
        end
        a0  = ($urandom_range(0, 99) < 85) ? cfg_addr_q : 8'($urandom);
        fn  = ($urandom_range(0, 99) < 88) ? FUNC_READ_INPUTS : 8'($urandom);
        sel = $urandom_range(0, 199);
        if (sel == 0)
            cnt = $urandom_range(251, 255);
        else if (sel < 4)
            cnt = $urandom_range(100, 250);
        else if (sel < 30)
            cnt = $urandom_range(9, 40);
        else
            cnt = $urandom_range(0, 8);
        flo = '0;
        fhi = '0;
        if ($urandom_range(0, 99) < 12) begin
            if ($urandom_range(0, 1))
                flo = 8'($urandom_range(1, 255));
            else
                fhi = 8'($urandom_range(1, 255));
        end
        st0   = ($urandom_range(0, 99) < 92);
        total = cnt + 5;
        cut   = ($urandom_range(0, 99) < 8) ? $urandom_range(0, total - 1) : total;
        for (int k = 0; k < cut; k++) begin
            if (k == 0)
                b = a0;
            else if (k == 1)
                b = fn;
            else if (k == 2)
                b = 8'(cnt);
            else if (k < cnt + 3)
                b = 8'($urandom);
            else if (k == cnt + 3)
                b = fr_crc[7:0] ^ flo;
            else
                b = fr_crc[15:8] ^ fhi;
            feed_byte(b, (k == 0) ? st0 : 1'b0);
        end
        if ($urandom_range(0, 99) < 10)
            feed_byte(8'($urandom), 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_EXPECTED_ADDRESS: cfg_addr_q  = val[BYTE_W-1:0];
            CFG_FIRST_INPUT:      cfg_first_q = val;
            CFG_INPUT_COUNT:      cfg_count_q = val[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // stop sending and let every expected result drain
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    initial begin
        forever begin
            @(hold_go);
            hold_on = 1'b1;
            repeat (LONG_HOLD) @(posedge aclk);
            hold_on = 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (hold_on)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_result_kind, m_first_register, m_bit_values, m_bit_count,
                    m_frame_status, m_resp_address, m_resp_function};
            if (got.kind == KIND_DATA)
                n_data++;
            else if (got.status == STATUS_OK)
                n_ok++;
            else if (got.status == STATUS_CRC_ERR)
                n_crc_err++;
            else
                n_mismatch++;
            if (pending_results.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("unexpected result: %s", result_str(got));
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.first_reg !== want.first_reg ||
                    got.bit_vals !== want.bit_vals || got.nbits !== want.nbits ||
                    got.status !== want.status || got.addr !== want.addr ||
                    got.func !== want.func) begin
                    if (errors < MAX_REPORTS) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", result_str(want));
                        $display("  actual   %s", result_str(got));
                    end
                    errors++;
                end
            end
        end
    end

    initial begin
        stim_row_t          row;
        logic [BYTE_W-1:0]  b;
        logic               got;
        logic               ign;
        result_t            r;
        logic [BYTE_W-1:0]  a;
        logic [REG_NUM_W-1:0] f;
        logic [COUNT_W-1:0] c;
        int                 start;

        // register defaults throughout the table: address 1, first input 0, count 1
        dir_rows = '{
            // first byte after reset is an address even without frame start
            '{8'h01, 1'b0, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'h02, 1'b0, SRC_LIT,    8'h00, CHK_MODEL, NO_RES},
            '{8'h02, 1'b0, SRC_LIT,    8'h00, CHK_MODEL, NO_RES},
            '{8'hFF, 1'b0, SRC_LIT,    8'h00, CHK_TYPED,
              '{KIND_DATA, 16'h0000, 8'h01, 4'd1, STATUS_OK, 8'h01, 8'h02}},
            // no requested bits left
            '{8'hAA, 1'b0, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'h00, 1'b0, SRC_CRC_LO, 8'h00, CHK_NONE,  NO_RES},
            '{8'h00, 1'b0, SRC_CRC_HI, 8'h00, CHK_TYPED,
              '{KIND_STATUS, 16'h0000, 8'h00, 4'd0, STATUS_OK, 8'h01, 8'h02}},
            // trailing byte after the frame is dropped
            '{8'h55, 1'b0, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            // zero byte count, bad CRC high byte
            '{8'h01, 1'b1, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'h02, 1'b0, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'h00, 1'b0, SRC_LIT,    8'h00, CHK_MODEL, NO_RES},
            '{8'h00, 1'b0, SRC_CRC_LO, 8'h00, CHK_NONE,  NO_RES},
            '{8'h00, 1'b0, SRC_CRC_HI, 8'h01, CHK_TYPED,
              '{KIND_STATUS, 16'h0000, 8'h00, 4'd0, STATUS_CRC_ERR, 8'h01, 8'h02}},
            // wrong address and function with a good CRC
            '{8'hFF, 1'b1, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'hFF, 1'b0, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'h01, 1'b0, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'h00, 1'b0, SRC_LIT,    8'h00, CHK_TYPED,
              '{KIND_DATA, 16'h0000, 8'h00, 4'd1, STATUS_OK, 8'hFF, 8'hFF}},
            '{8'h00, 1'b0, SRC_CRC_LO, 8'h00, CHK_NONE,  NO_RES},
            '{8'h00, 1'b0, SRC_CRC_HI, 8'h00, CHK_TYPED,
              '{KIND_STATUS, 16'h0000, 8'h00, 4'd0, STATUS_MISMATCH, 8'hFF, 8'hFF}},
            // oversized byte count, then a restart in the middle of the data
            '{8'h00, 1'b1, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'h02, 1'b0, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'hFF, 1'b0, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'h80, 1'b0, SRC_LIT,    8'h00, CHK_TYPED,
              '{KIND_DATA, 16'h0000, 8'h00, 4'd1, STATUS_OK, 8'h00, 8'h02}},
            '{8'h7F, 1'b1, SRC_LIT,    8'h00, CHK_NONE,  NO_RES},
            '{8'h02, 1'b0, SRC_LIT,    8'h00, CHK_MODEL, NO_RES}
        };

        model_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            case (row.src)
                SRC_CRC_LO: b = fr_crc[7:0] ^ row.flip;
                SRC_CRC_HI: b = fr_crc[15:8] ^ row.flip;
                default:    b = row.val;
            endcase
            parse_byte(b, row.st, got, r, ign);
            if (row.chk == CHK_MODEL) begin
                if (got)
                    pending_results.push_back(r);
            end else if (row.chk == CHK_TYPED) begin
                pending_results.push_back(row.want);
            end
            if (!ign)
                bytes_taken++;
            drive_byte(b, row.st);
        end
        wait_quiet();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin a = 8'h01; f = 16'h0000; c = 11'd2000; end
                1: begin a = 8'hFF; f = 16'hFFFF; c = 11'd1;    end
                2: begin a = 8'h00; f = 16'hFFF0; c = 11'd2000; end
                4: begin a = 8'($urandom); f = 16'($urandom); c = 11'd0; end
                5: begin a = 8'($urandom); f = 16'($urandom); c = 11'd2047; end
                6: begin
                    a = 8'($urandom);
                    f = 16'($urandom);
                    c = 11'($urandom_range(1, 64));
                end
                default: begin
                    a = 8'($urandom);
                    f = 16'($urandom);
                    c = 11'($urandom_range(1, 2000));
                end
            endcase
            write_reg(CFG_EXPECTED_ADDRESS, {8'h00, a});
            write_reg(CFG_FIRST_INPUT, f);
            write_reg(CFG_INPUT_COUNT, {5'b00000, c});
            cfg_we <= 1'b0;
            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 48; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 48; end
                default: begin snd_idle_pct = 23; rcv_stall_pct = 23; end
            endcase
            // long receiver hold while bytes keep coming, so the input backs up
            if (ph == 0)
                -> hold_go;
            start = bytes_taken;
            while (bytes_taken - start < PHASE_BYTES)
                send_random_frame();
            wait_quiet();
        end

        errors += pending_results.size();
        $display("covered %0d bytes in %0d random frames over %0d register settings",
                 bytes_taken, frames_sent, N_PHASES + 1);
        $display("results: %0d data, %0d ok, %0d CRC error, %0d mismatch",
                 n_data, n_ok, n_crc_err, n_mismatch);
        if (errors == 0)
            $display("tb_modbus_read_inputs_response_parser_core passed");
        else
            $display("tb_modbus_read_inputs_response_parser_core failed");
        $finish;
    end

endmodule
